### rtl/core/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

	// fixed field widths
	localparam int ANGLE_W = 32;
	localparam int TAN_W   = 48;
	localparam int TC_W    = 7;
	localparam int QW      = TAN_W + 1;

	// configuration port
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_TERM_COUNT = 1'b0;

	localparam logic [TC_W-1:0] TERM_COUNT_RST = TC_W'(10);

	// saturation bounds and quotient limit
	localparam logic [TAN_W-1:0] TAN_MAX = {1'b0, {(TAN_W-1){1'b1}}};
	localparam logic [TAN_W-1:0] TAN_MIN = {1'b1, {(TAN_W-1){1'b0}}};
	localparam logic [QW-1:0]    Q_LIM   = QW'(1) << (TAN_W - 1);

endpackage

`default_nettype wire

### rtl/core/tcf_in_if.sv
`default_nettype none

interface tcf_in_if
	import tcf_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

### rtl/core/tcf_out_if.sv
`default_nettype none

interface tcf_out_if
	import tcf_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [TAN_W-1:0] tangent;
	logic                    overflow;

	modport source (output valid, output tangent, output overflow, input ready);
	modport sink   (input valid, input tangent, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/tangent_continued_fraction.sv
// Tangent of a fixed-point angle by a truncated Lambert continued fraction.
// req carries one angle word (signed, FRAC_BITS fraction bits); rsp returns
// one word per angle: the saturated tangent (same format) and an overflow
// flag that is set when any term saturated or met a zero denominator.
// The APB port holds term_count at byte address 0 (zero acts as one, values
// above MAX_TERMS act as MAX_TERMS); write it only while the block is idle.
// After accept the sequencer squares the angle, then for each of the k terms
// (k the clamped term count) sets up and loads the denominator, divides
// NUM_W = max(64, 32+FRAC_BITS) numerator bits and fixes sign and saturation.
// One restoring divider, one quotient bit per cycle, is shared by all k terms.
// req.ready is high only when the sequencer is idle, so one angle is in work
// at a time; a new angle is taken only once the last one has finished. The
// result waits in an output register; a new angle is taken while it waits,
// and the sequencer holds its next result until rsp.ready.
// Reset (arst_n low) empties the sequencer and output register and sets
// term_count to 10.
`default_nettype none

module tangent_continued_fraction
	import tcf_pkg::*;
#(
	parameter int MAX_TERMS = 64,
	parameter int FRAC_BITS = 24
) (
	input  wire               clk,
	input  wire               arst_n,
	tcf_in_if.sink            req,
	tcf_out_if.source         rsp,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [APB_AW-1:0] paddr,
	input  wire  [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int DD_W   = $clog2(2 * MAX_TERMS) + FRAC_BITS;
	localparam int DEN_W  = ((DD_W > TAN_W) ? DD_W : TAN_W) + 2;
	localparam int NUM_W  = (2 * ANGLE_W > ANGLE_W + FRAC_BITS) ?
	                        2 * ANGLE_W : ANGLE_W + FRAC_BITS;
	localparam int NUM_BW = $clog2(NUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_SETUP,
		ST_LOAD,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [TC_W-1:0]        term_count_q;
	logic [ANGLE_W-1:0]     xmag_q;
	logic                   xneg_q;
	logic [2*ANGLE_W-1:0]   xsq_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   first_q;
	logic [TAN_W-1:0]       val_q;
	logic                   ovf_q;
	logic [DEN_W-1:0]       den_q;
	logic [DEN_W-1:0]       dmag_q;
	logic                   den_neg_q;
	logic                   den_zero_q;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       r_q;
	logic [QW-1:0]          q_q;
	logic                   big_q;
	logic [NUM_BW-1:0]      bit_q;
	logic                   out_valid_q;
	logic [TAN_W-1:0]       out_tan_q;
	logic                   out_ovf_q;

	// apb register
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RST;
		end else if (cfg_wr && paddr[2] == REG_TERM_COUNT) begin
			term_count_q <= pwdata[TC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TERM_COUNT) begin
			prdata = APB_DW'(term_count_q);
		end
	end

	// clamped term count
	logic [CNT_W-1:0] k_clamp;
	always_comb begin
		if (term_count_q == '0) begin
			k_clamp = CNT_W'(1);
		end else if (32'(term_count_q) > 32'(MAX_TERMS)) begin
			k_clamp = CNT_W'(MAX_TERMS);
		end else begin
			k_clamp = CNT_W'(term_count_q);
		end
	end

	// angle magnitude
	logic [ANGLE_W-1:0] angle_mag;
	assign angle_mag = req.angle[ANGLE_W-1] ? ANGLE_W'(-req.angle) : ANGLE_W'(req.angle);

	// denominator of the current term: (2i-1) << FRAC_BITS, less the deeper value
	logic [CNT_W:0]   odd;
	logic [DEN_W-1:0] dd;
	logic [DEN_W-1:0] den_next;
	assign odd      = {cnt_q, 1'b0} - (CNT_W+1)'(1);
	assign dd       = DEN_W'(odd) << FRAC_BITS;
	assign den_next = first_q ? dd : dd - {{(DEN_W-TAN_W){val_q[TAN_W-1]}}, val_q};

	// one restoring divide step
	logic [DEN_W:0]  r_shift;
	logic [DEN_W:0]  r_diff;
	logic            q_bit;
	logic [QW-1:0]   q_next;
	assign r_shift = {r_q, num_q[NUM_W-1]};
	assign r_diff  = r_shift - {1'b0, dmag_q};
	assign q_bit   = !r_diff[DEN_W];
	assign q_next  = {q_q[QW-2:0], q_bit};

	// sign and saturation of the finished quotient
	logic             last_term;
	logic             num_neg;
	logic             res_neg;
	logic [TAN_W-1:0] fix_val;
	logic             fix_ovf;
	assign last_term = (cnt_q == CNT_W'(1));
	assign num_neg   = last_term && xneg_q;
	assign res_neg   = (num_neg != den_neg_q) && (xmag_q != '0);

	always_comb begin
		fix_ovf = 1'b0;
		if (den_zero_q) begin
			fix_ovf = 1'b1;
			fix_val = num_neg ? TAN_MIN : TAN_MAX;
		end else if (res_neg) begin
			if (big_q) begin
				fix_ovf = 1'b1;
				fix_val = TAN_MIN;
			end else begin
				fix_val = ~q_q[TAN_W-1:0] + TAN_W'(1);
			end
		end else begin
			if (big_q || q_q == Q_LIM) begin
				fix_ovf = 1'b1;
				fix_val = TAN_MAX;
			end else begin
				fix_val = q_q[TAN_W-1:0];
			end
		end
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.tangent  = out_tan_q;
	assign rsp.overflow = out_ovf_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			xmag_q      <= '0;
			xneg_q      <= 1'b0;
			xsq_q       <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			val_q       <= '0;
			ovf_q       <= 1'b0;
			den_q       <= '0;
			dmag_q      <= '0;
			den_neg_q   <= 1'b0;
			den_zero_q  <= 1'b0;
			num_q       <= '0;
			r_q         <= '0;
			q_q         <= '0;
			big_q       <= 1'b0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			out_tan_q   <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						xmag_q  <= angle_mag;
						xneg_q  <= req.angle[ANGLE_W-1];
						cnt_q   <= k_clamp;
						first_q <= 1'b1;
						ovf_q   <= 1'b0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					xsq_q   <= xmag_q * xmag_q;
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					den_q   <= den_next;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					den_neg_q  <= den_q[DEN_W-1];
					dmag_q     <= den_q[DEN_W-1] ? -den_q : den_q;
					den_zero_q <= (den_q == '0);
					num_q      <= last_term ? (NUM_W'(xmag_q) << FRAC_BITS) : NUM_W'(xsq_q);
					r_q        <= '0;
					q_q        <= '0;
					big_q      <= 1'b0;
					bit_q      <= NUM_BW'(NUM_W - 1);
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					r_q   <= q_bit ? r_diff[DEN_W-1:0] : r_shift[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					if (!big_q) begin
						q_q   <= q_next;
						big_q <= (q_next > Q_LIM);
					end
					bit_q <= bit_q - NUM_BW'(1);
					if (bit_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					val_q   <= fix_val;
					ovf_q   <= ovf_q | fix_ovf;
					first_q <= 1'b0;
					if (last_term) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_SETUP;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_tan_q   <= val_q;
						out_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted word closes the input until the sequencer is idle again
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input taken while busy");

	// term counter stays in range while a word is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP || state_q == ST_LOAD || state_q == ST_DIV ||
		 state_q == ST_FIX)
		|-> (cnt_q != '0 && 32'(cnt_q) <= 32'(MAX_TERMS)))
		else $error("term counter out of range");

	// quotient below the saturation flag never passes the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX && !big_q) |-> (q_q <= Q_LIM))
		else $error("quotient exceeds limit without saturation");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.tangent) &&
		 $stable(rsp.overflow)))
		else $error("pending result lost");

	// the divider runs from a remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !den_zero_q) |-> (r_q < dmag_q))
		else $error("remainder not below divisor");

endmodule

`default_nettype wire
